[hw/rtl/lrts_pkg.sv]
package lrts_pkg;

    localparam int ID_W    = 4;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;

    localparam int S_DATA_W = ((ID_W + BURST_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ID_W + 1 + TIME_W + 7) / 8) * 8;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

endpackage

[hw/rtl/longest_remaining_time_scheduler.sv]
// channel | dir | tdata                                  | tuser
// s_*     | in  | proc_id[3:0], burst[19:4], 0[23:20]    | kind
// m_*     | out | ran_id[3:0], finished[4], now[36:5], 0 | busy_res
//
// Admit: written into the slot memory from IDLE. Tick: resolved by one
// comparator walking the slot memory one entry per cycle, then DRAIN and COMMIT.
// Reset clears slot-valid bits and time; slot memory itself is not cleared.
// A finished tick waits in COMMIT while the output register is still held.
module longest_remaining_time_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lrts_pkg::S_DATA_W-1:0]  s_tdata,   // proc_id, burst
    input  logic                           s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lrts_pkg::M_DATA_W-1:0]  m_tdata,   // ran_id, finished, now
    output logic                           m_tuser    // busy_res
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int ID_W  = lrts_pkg::ID_W;
    localparam int BW    = lrts_pkg::BURST_W;
    localparam int TW    = lrts_pkg::TIME_W;

    lrts_pkg::state_t state_reg, state_next;

    logic [BW-1:0]        mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] nz_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [BW-1:0]    rd_data_reg;
    logic             rd_nz_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;

    logic [BW-1:0]    best_rem_reg;
    logic [IDX_W-1:0] best_idx_reg;

    logic [TW-1:0]    time_reg;

    logic             out_vld_reg;
    logic             out_busy_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic             out_fin_reg;
    logic [TW-1:0]    out_time_reg;

    logic [ID_W-1:0]  in_id;
    logic [BW-1:0]    in_burst;
    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] admit_idx;
    logic             admit_ok;
    logic             commit_go;
    logic             found;
    logic             done;
    logic [BW-1:0]    cand;
    logic             last_issue;

    assign in_id     = s_tdata[ID_W-1:0];
    assign in_burst  = s_tdata[ID_W+BW-1:ID_W];
    assign s_tready  = (state_reg == lrts_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_range  = (32'(in_id) < MAX_PROCS);
    assign admit_idx = IDX_W'(in_id);
    assign admit_ok  = accept && (s_tuser == lrts_pkg::KIND_ADMIT) && in_range
                       && !nz_reg[admit_idx] && (in_burst != '0);
    assign commit_go = (state_reg == lrts_pkg::ST_COMMIT) && (!out_vld_reg || m_tready);
    assign found     = (best_rem_reg != '0);
    assign done      = (best_rem_reg == BW'(1));
    assign cand      = rd_nz_reg ? rd_data_reg : '0;
    assign last_issue = (scan_idx_reg == IDX_W'(MAX_PROCS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrts_pkg::ST_IDLE:
            begin
                if (accept && s_tuser == lrts_pkg::KIND_TICK)
                    state_next = lrts_pkg::ST_SCAN;
            end
            lrts_pkg::ST_SCAN:
            begin
                if (last_issue)
                    state_next = lrts_pkg::ST_DRAIN;
            end
            lrts_pkg::ST_DRAIN:
            begin
                state_next = lrts_pkg::ST_COMMIT;
            end
            lrts_pkg::ST_COMMIT:
            begin
                if (commit_go)
                    state_next = lrts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lrts_pkg::ST_IDLE;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (admit_ok)
            mem[admit_idx] <= in_burst;
        else if (commit_go && found)
            mem[best_idx_reg] <= best_rem_reg - BW'(1);
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[scan_idx_reg];
        rd_nz_reg   <= nz_reg[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lrts_pkg::ST_IDLE;
            nz_reg       <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            best_rem_reg <= '0;
            best_idx_reg <= '0;
            time_reg     <= '0;
            out_vld_reg  <= 1'b0;
            out_busy_reg <= 1'b0;
            out_id_reg   <= '0;
            out_fin_reg  <= 1'b0;
            out_time_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == lrts_pkg::ST_SCAN);

            if (commit_go)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;

            if (admit_ok)
                nz_reg[admit_idx] <= 1'b1;

            if (state_reg == lrts_pkg::ST_IDLE)
            begin
                scan_idx_reg <= '0;
                best_rem_reg <= '0;
                best_idx_reg <= '0;
            end
            else if (state_reg == lrts_pkg::ST_SCAN && !last_issue)
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);

            // strictly greater keeps the lower id on ties
            if (rd_vld_reg && cand > best_rem_reg)
            begin
                best_rem_reg <= cand;
                best_idx_reg <= rd_idx_reg;
            end

            if (commit_go)
            begin
                if (found && done)
                    nz_reg[best_idx_reg] <= 1'b0;
                out_busy_reg <= found;
                out_id_reg   <= found ? ID_W'(best_idx_reg) : '0;
                out_fin_reg  <= found && done;
                if (time_reg != lrts_pkg::TIME_MAX)
                begin
                    time_reg     <= time_reg + TW'(1);
                    out_time_reg <= time_reg + TW'(1);
                end
                else
                    out_time_reg <= time_reg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_busy_reg;
    assign m_tdata  = lrts_pkg::M_DATA_W'({out_time_reg, out_fin_reg, out_id_reg});

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC      = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE     = 40;
    localparam int HOLD_START = 3000;
    localparam int HOLD_LEN   = 500;
    localparam int FIN_BIT    = lrts_pkg::ID_W;
    localparam int NOW_LSB    = lrts_pkg::ID_W + 1;

    typedef struct {
        logic                         kind;
        logic [lrts_pkg::ID_W-1:0]    pid;
        logic [lrts_pkg::BURST_W-1:0] burst;
        bit                           wait_drain;
    } sched_cmd_t;

    typedef struct packed {
        logic                         busy;
        logic [lrts_pkg::ID_W-1:0]    ran_id;
        logic                         finished;
        logic [lrts_pkg::TIME_W-1:0]  now;
    } dispatch_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lrts_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lrts_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;

    sched_cmd_t  cmd_q[$];
    sched_cmd_t  cur_cmd;
    dispatch_t   dispatch_q[$];

    // scheduler shadow state
    logic [lrts_pkg::BURST_W-1:0] remaining [NPROC];
    logic [lrts_pkg::TIME_W-1:0]  sched_time = '0;

    int  err_count = 0;
    int  cycle_count = 0;
    int  work_bound = 0;
    bit  drain_next = 1'b0;
    int  gap_left = 0;
    int  burst_left = 1;

    longest_remaining_time_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // proc_id, burst
        .s_tuser  (s_tuser),   // kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // ran_id, finished, now
        .m_tuser  (m_tuser)    // busy_res
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        for (int i = 0; i < NPROC; i++)
        begin
            remaining[i] = '0;
        end
    end

    function automatic dispatch_t run_tick();
        dispatch_t                    d;
        int                           best;
        logic [lrts_pkg::BURST_W-1:0] best_rem;
        d = '0;
        best = 0;
        best_rem = '0;
        for (int i = 0; i < NPROC; i++)
        begin
            if (remaining[i] > best_rem)
            begin
                best_rem = remaining[i];
                best = i;
            end
        end
        if (sched_time != lrts_pkg::TIME_MAX)
            sched_time = sched_time + lrts_pkg::TIME_W'(1);
        if (best_rem != '0)
        begin
            remaining[best] = remaining[best] - lrts_pkg::BURST_W'(1);
            d.busy = 1'b1;
            d.ran_id = best[lrts_pkg::ID_W-1:0];
            d.finished = (remaining[best] == '0);
        end
        d.now = sched_time;
        return d;
    endfunction

    function automatic logic [lrts_pkg::BURST_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return lrts_pkg::BURST_W'($urandom_range(21, 300));
        else
            return lrts_pkg::BURST_W'($urandom_range(1, 20));
    endfunction

    task automatic push_admit(input int id, input logic [lrts_pkg::BURST_W-1:0] b);
        sched_cmd_t c;
        c.kind = lrts_pkg::KIND_ADMIT;
        c.pid = id[lrts_pkg::ID_W-1:0];
        c.burst = b;
        c.wait_drain = drain_next;
        drain_next = 1'b0;
        work_bound += int'(b);
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic push_tick();
        sched_cmd_t c;
        c.kind = lrts_pkg::KIND_TICK;
        c.pid = lrts_pkg::ID_W'($urandom_range(0, NPROC - 1));
        c.burst = lrts_pkg::BURST_W'($urandom);
        c.wait_drain = drain_next;
        drain_next = 1'b0;
        if (work_bound > 0)
            work_bound--;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        bit take;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_cmd.kind == lrts_pkg::KIND_ADMIT)
                begin
                    if (remaining[cur_cmd.pid] == '0)
                        remaining[cur_cmd.pid] = cur_cmd.burst;
                end
                else
                begin
                    dispatch_q.insert(dispatch_q.size(), run_tick());
                end
            end
            if (!s_tvalid || s_tready)
            begin
                take = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].wait_drain && dispatch_q.size() > 0))
                    take = 1'b1;
                if (take)
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_tdata <= {{(lrts_pkg::S_DATA_W - lrts_pkg::ID_W
                                  - lrts_pkg::BURST_W){1'b0}},
                                cur_cmd.burst, cur_cmd.pid};
                    s_tuser <= cur_cmd.kind;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                        burst_left = $urandom_range(0, 5) == 0 ? $urandom_range(60, 200)
                                                               : $urandom_range(1, 20);
                    end
                end
                s_tvalid <= take;
            end
        end
    end

    // receiver: stall pattern in modes, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        int rx_cycles;
        int mode_left;
        int mode;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycles = 0;
            mode_left = 0;
            mode = 0;
        end
        else
        begin
            rx_cycles++;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 128);
            end
            mode_left--;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
                m_tready <= 1'b0;
            else if (mode == 0)
                m_tready <= 1'b1;
            else if (mode == 1)
                m_tready <= $urandom_range(0, 3) != 0;
            else
                m_tready <= $urandom_range(0, 3) == 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        dispatch_t exp_d;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dispatch_q.size() == 0)
            begin
                $error("unexpected result transfer: tdata=%h tuser=%b", m_tdata, m_tuser);
                err_count++;
            end
            else
            begin
                exp_d = dispatch_q.pop_front();
                if (m_tuser !== exp_d.busy)
                begin
                    $error("busy_res: expected %0d, got %0d", exp_d.busy, m_tuser);
                    err_count++;
                end
                if (m_tdata[lrts_pkg::ID_W-1:0] !== exp_d.ran_id)
                begin
                    $error("ran_id: expected %0d, got %0d", exp_d.ran_id,
                           m_tdata[lrts_pkg::ID_W-1:0]);
                    err_count++;
                end
                if (m_tdata[FIN_BIT] !== exp_d.finished)
                begin
                    $error("finished: expected %0d, got %0d", exp_d.finished,
                           m_tdata[FIN_BIT]);
                    err_count++;
                end
                if (m_tdata[NOW_LSB +: lrts_pkg::TIME_W] !== exp_d.now)
                begin
                    $error("now: expected %0d, got %0d", exp_d.now,
                           m_tdata[NOW_LSB +: lrts_pkg::TIME_W]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n_adm;
        int planned;
        int extra;
        logic [lrts_pkg::BURST_W-1:0] b;

        // directed: idle, zero burst, tie, busy slot, tick with ignored fields
        push_tick();
        push_admit(0, '0);
        push_tick();
        push_admit(NPROC - 1, lrts_pkg::BURST_W'(3));
        push_admit(0, lrts_pkg::BURST_W'(3));
        push_admit(NPROC - 1, lrts_pkg::BURST_W'(9));
        repeat (6) push_tick();
        push_tick();
        push_admit(5, lrts_pkg::BURST_W'(1));
        cmd_q.insert(cmd_q.size(), '{lrts_pkg::KIND_TICK, {lrts_pkg::ID_W{1'b1}},
                                     {lrts_pkg::BURST_W{1'b1}}, 1'b0});
        push_tick();
        push_admit(10, lrts_pkg::BURST_W'(2));
        push_admit(9, lrts_pkg::BURST_W'(2));
        push_tick();
        push_tick();
        push_tick();
        push_tick();
        work_bound = 0;

        // random: well-formed admit/run phases, some left partly drained
        drain_next = 1'b1;
        while (cmd_q.size() + work_bound < 1600)
        begin
            n_adm = $urandom_range(1, 6);
            planned = 0;
            repeat (n_adm)
            begin
                b = pick_burst();
                push_admit($urandom_range(0, NPROC - 1), b);
                planned += int'(b);
            end
            if ($urandom_range(0, 3) == 0)
                planned = $urandom_range(0, planned);
            else
                planned += $urandom_range(0, 3);
            repeat (planned)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_admit($urandom_range(0, NPROC - 1), pick_burst());
                push_tick();
            end
        end
        extra = work_bound;
        repeat (extra) push_tick();

        // tail: largest bursts once every slot has drained
        drain_next = 1'b1;
        push_admit(3, {lrts_pkg::BURST_W{1'b1}});
        push_admit(12, lrts_pkg::BURST_W'(16'h8000));
        push_admit(NPROC - 1, lrts_pkg::BURST_W'(16'h7FFF));
        repeat (4) push_tick();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (dispatch_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
